[src/assert_macros.svh]
// Assertion helper macros for the delta-list scheduler RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Same, on the house clock and reset names.
`define ASSERT_STD(lbl, prop) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

[src/dlts_pkg.sv]
// Shared types and constants of the delta-list task scheduler.
// No dependencies; used by dlts_mem, dlts_conv, the scheduler core and the testbench.
`default_nettype none

package dlts_pkg;

  localparam int unsigned MaxTasks   = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned TickMax    = 65535;
  // floor(ms / 10) == (ms * RecipMul) >> RecipShift for all 20-bit ms
  localparam int unsigned RecipMul   = 838861;
  localparam int unsigned RecipShift = 23;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_FIRED    = 3'd0,
    K_INSERTED = 3'd1,
    K_FULL     = 3'd2,
    K_DELETED  = 3'd3,
    K_NOTFOUND = 3'd4,
    K_NONE     = 3'd5
  } kind_e;

  typedef struct packed {
    logic [16:0] delta;
    logic [15:0] period;
    logic [7:0]  task_id;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CONV, S_PRD, S_PCHK, S_SHRD, S_SHWR, S_PWR, S_DRD,
    S_DCHK, S_DSRD, S_DSWR, S_TSTART, S_TDEC, S_TRD, S_TCHK, S_EMIT
  } state_e;

endpackage

`default_nettype wire

[src/dlts_in_if.sv]
// Input channel of the scheduler: valid/ready plus one command item.
// No dependencies.
`default_nettype none

interface dlts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [19:0] delay_ms;
  logic [19:0] period_ms;
  logic [7:0]  task_id;

  modport source (output valid, operation, delay_ms, period_ms, task_id, input ready);
  modport sink   (input valid, operation, delay_ms, period_ms, task_id, output ready);
endinterface

`default_nettype wire

[src/dlts_out_if.sv]
// Result channel of the scheduler: valid/ready plus one result item.
// No dependencies.
`default_nettype none

interface dlts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] fired_id;
  logic       last;

  modport source (output valid, kind, fired_id, last, input ready);
  modport sink   (input valid, kind, fired_id, last, output ready);
endinterface

`default_nettype wire

[src/dlts_mem.sv]
// Task table memory: one write port, one read port with registered data.
// Depends on dlts_pkg (entry_t).
`default_nettype none

module dlts_mem #(
  parameter int unsigned Depth = dlts_pkg::MaxTasks,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  dlts_pkg::entry_t     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output dlts_pkg::entry_t     rdata_o
);

  dlts_pkg::entry_t mem_q [Depth];
  dlts_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds when no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/dlts_conv.sv]
// Millisecond to tick converter: divide by 10 via reciprocal multiply, saturate.
// Depends on dlts_pkg (constants). The product is registered: result valid in the cycle after en_i.
`default_nettype none

module dlts_conv (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [19:0] ms_i,
  output logic [15:0] ticks_o
);

  logic [39:0] prod_q;
  logic [16:0] quot;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 40'(ms_i) * 40'(dlts_pkg::RecipMul);
    end
  end

  assign quot    = 17'(prod_q >> dlts_pkg::RecipShift);
  assign ticks_o = (quot > 17'(dlts_pkg::TickMax)) ? 16'(dlts_pkg::TickMax) : quot[15:0];

endmodule

`default_nettype wire

[src/delta_list_task_scheduler_core.sv]
// Delta-list task scheduler: top level with the command sequencer.
// Depends on dlts_pkg, dlts_in_if, dlts_out_if, dlts_mem, dlts_conv, assert_macros.svh.
// Usage:
//   in_i carries commands (tick, insert, delete); out_o carries results
//   (kind, fired_id, last). A transaction completes when valid and ready are high.
//   Every command but the unused code gives one or more results; the final one has
//   last set. A tick gives one fired result per due task, up to 16, or one none-due.
// Sequencing:
//   One command at a time; in_i.ready is high only while the sequencer is idle.
//   Every list step reads the task memory (registered read) in one state and
//   checks or writes back in the next, one entry visited or shifted at a time.
//   An insert scans for its position, then shifts the tail up; a delete searches
//   by id, then shifts down; a tick drops each fired task, then reinserts a periodic one.
//   The time a command takes grows with the number of used entries scanned or shifted.
// Reset:
//   The list is empty after reset; the memory is not cleared, only entries below
//   the used count are read. No clearing pass is needed.
// Stall:
//   Results go through an output register. A stalled receiver holds the sequencer
//   at its next result; no result is lost or repeated.
`default_nettype none
`include "assert_macros.svh"

module delta_list_task_scheduler_core #(
  parameter int unsigned MAX_TASKS = dlts_pkg::MaxTasks
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlts_in_if.sink    in_i,
  dlts_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(MAX_TASKS);
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned KW   = $clog2(dlts_pkg::MaxResults + 1);

  dlts_pkg::state_e state_q, state_d;
  dlts_pkg::op_e    op_q, op_d;
  dlts_pkg::kind_e  kind_q, kind_d;
  dlts_pkg::kind_e  okind_q, okind_d;

  logic [CntW-1:0] n_q, n_d;       // used entries
  logic [CntW-1:0] pos_q, pos_d;   // scan / target position
  logic [CntW-1:0] i_q, i_d;       // shift index
  logic [KW-1:0]   k_q, k_d;       // fired count this tick
  logic [16:0]     cum_q, cum_d;   // cumulative time before pos
  logic [16:0]     dd_q, dd_d;     // delta of dropped entry
  logic [15:0]     time_q, time_d;
  logic [15:0]     per_q, per_d;
  logic [7:0]      id_q, id_d;
  logic [7:0]      res_id_q, res_id_d;
  logic [7:0]      pend_id_q, pend_id_d;
  logic [7:0]      oid_q, oid_d;
  logic            after_q, after_d;
  logic            pend_q, pend_d;
  logic            ov_q, ov_d;
  logic            olast_q, olast_d;

  // memory port
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  dlts_pkg::entry_t mem_wdata, mem_rdata;

  logic [15:0] dly_ticks, per_ticks;
  logic        in_acc, out_free, cmd_acc;
  logic [17:0] nxt;
  logic [16:0] nd;
  logic [CntW-1:0] im1, ip1;

  assign in_acc   = in_i.valid && in_i.ready;
  assign cmd_acc  = in_acc && (in_i.operation != dlts_pkg::OP_NOP);
  assign out_free = !ov_q || out_o.ready;
  assign nxt      = {1'b0, cum_q} + {1'b0, mem_rdata.delta};
  assign nd       = {1'b0, time_q} - cum_q;
  assign im1      = i_q - CntW'(1);
  assign ip1      = i_q + CntW'(1);

  dlts_conv u_conv_dly (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .ms_i    (in_i.delay_ms),
    .ticks_o (dly_ticks)
  );

  dlts_conv u_conv_per (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .ms_i    (in_i.period_ms),
    .ticks_o (per_ticks)
  );

  dlts_mem #(.Depth(MAX_TASKS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlts_pkg::S_IDLE;
      n_q     <= '0;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      ov_q    <= ov_d;
      pend_q  <= pend_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    kind_q    <= kind_d;
    okind_q   <= okind_d;
    pos_q     <= pos_d;
    i_q       <= i_d;
    cum_q     <= cum_d;
    dd_q      <= dd_d;
    time_q    <= time_d;
    per_q     <= per_d;
    id_q      <= id_d;
    res_id_q  <= res_id_d;
    pend_id_q <= pend_id_d;
    oid_q     <= oid_d;
    after_q   <= after_d;
    olast_q   <= olast_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    kind_d    = kind_q;
    okind_d   = okind_q;
    n_d       = n_q;
    pos_d     = pos_q;
    i_d       = i_q;
    k_d       = k_q;
    cum_d     = cum_q;
    dd_d      = dd_q;
    time_d    = time_q;
    per_d     = per_q;
    id_d      = id_q;
    res_id_d  = res_id_q;
    pend_id_d = pend_id_q;
    oid_d     = oid_q;
    after_d   = after_q;
    pend_d    = pend_q;
    olast_d   = olast_q;
    ov_d      = ov_q && !out_o.ready;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = mem_rdata;

    unique case (state_q)
      dlts_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d    = dlts_pkg::op_e'(in_i.operation);
          id_d    = in_i.task_id;
          k_d     = '0;
          pend_d  = 1'b0;
          pos_d   = '0;
          cum_d   = '0;
          after_d = 1'b0;
          unique case (dlts_pkg::op_e'(in_i.operation))
            dlts_pkg::OP_TICK:   state_d = dlts_pkg::S_TSTART;
            dlts_pkg::OP_INSERT: state_d = dlts_pkg::S_CONV;
            dlts_pkg::OP_DELETE: state_d = dlts_pkg::S_DRD;
            default:             state_d = dlts_pkg::S_IDLE;
          endcase
        end
      end
      dlts_pkg::S_CONV: begin
        time_d = dly_ticks;
        per_d  = per_ticks;
        if (n_q >= CntW'(MAX_TASKS)) begin
          kind_d   = dlts_pkg::K_FULL;
          res_id_d = id_q;
          state_d  = dlts_pkg::S_EMIT;
        end else begin
          state_d = dlts_pkg::S_PRD;
        end
      end
      // place: scan for the insert position
      dlts_pkg::S_PRD: begin
        if (pos_q < n_q) begin
          mem_re    = 1'b1;
          mem_raddr = pos_q[IdxW-1:0];
          state_d   = dlts_pkg::S_PCHK;
        end else begin
          i_d     = n_q;
          state_d = dlts_pkg::S_SHRD;
        end
      end
      dlts_pkg::S_PCHK: begin
        if (after_q ? (nxt > {2'b00, time_q}) : (nxt >= {2'b00, time_q})) begin
          i_d     = n_q;
          state_d = dlts_pkg::S_SHRD;
        end else begin
          cum_d   = nxt[16:0];
          pos_d   = pos_q + CntW'(1);
          state_d = dlts_pkg::S_PRD;
        end
      end
      // place: shift entries up from the tail
      dlts_pkg::S_SHRD: begin
        if (i_q > pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = im1[IdxW-1:0];
          state_d   = dlts_pkg::S_SHWR;
        end else begin
          state_d = dlts_pkg::S_PWR;
        end
      end
      dlts_pkg::S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = i_q[IdxW-1:0];
        mem_wdata = mem_rdata;
        if (im1 == pos_q) begin
          mem_wdata.delta = mem_rdata.delta - nd;  // successor keeps its due time
        end
        i_d     = im1;
        state_d = dlts_pkg::S_SHRD;
      end
      dlts_pkg::S_PWR: begin
        mem_we            = 1'b1;
        mem_waddr         = pos_q[IdxW-1:0];
        mem_wdata.delta   = nd;
        mem_wdata.period  = per_q;
        mem_wdata.task_id = id_q;
        n_d               = n_q + CntW'(1);
        if (op_q == dlts_pkg::OP_INSERT) begin
          kind_d   = dlts_pkg::K_INSERTED;
          res_id_d = id_q;
          state_d  = dlts_pkg::S_EMIT;
        end else begin
          state_d = dlts_pkg::S_TRD;
        end
      end
      // delete: search by id
      dlts_pkg::S_DRD: begin
        if (pos_q < n_q) begin
          mem_re    = 1'b1;
          mem_raddr = pos_q[IdxW-1:0];
          state_d   = dlts_pkg::S_DCHK;
        end else begin
          kind_d   = dlts_pkg::K_NOTFOUND;
          res_id_d = id_q;
          state_d  = dlts_pkg::S_EMIT;
        end
      end
      dlts_pkg::S_DCHK: begin
        if (mem_rdata.task_id == id_q) begin
          dd_d    = mem_rdata.delta;
          i_d     = pos_q;
          state_d = dlts_pkg::S_DSRD;
        end else begin
          pos_d   = pos_q + CntW'(1);
          state_d = dlts_pkg::S_DRD;
        end
      end
      // drop: shift entries down over pos
      dlts_pkg::S_DSRD: begin
        if (ip1 < n_q) begin
          mem_re    = 1'b1;
          mem_raddr = ip1[IdxW-1:0];
          state_d   = dlts_pkg::S_DSWR;
        end else begin
          n_d = n_q - CntW'(1);
          if (op_q == dlts_pkg::OP_DELETE) begin
            kind_d   = dlts_pkg::K_DELETED;
            res_id_d = id_q;
            state_d  = dlts_pkg::S_EMIT;
          end else if (per_q != 16'd0) begin
            pos_d   = '0;
            cum_d   = '0;
            after_d = 1'b1;
            state_d = dlts_pkg::S_PRD;
          end else begin
            state_d = dlts_pkg::S_TRD;
          end
        end
      end
      dlts_pkg::S_DSWR: begin
        mem_we    = 1'b1;
        mem_waddr = i_q[IdxW-1:0];
        mem_wdata = mem_rdata;
        if (i_q == pos_q) begin
          mem_wdata.delta = mem_rdata.delta + dd_q;
        end
        i_d     = ip1;
        state_d = dlts_pkg::S_DSRD;
      end
      // tick
      dlts_pkg::S_TSTART: begin
        if (n_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_d   = dlts_pkg::S_TDEC;
        end else begin
          state_d = dlts_pkg::S_TRD;
        end
      end
      dlts_pkg::S_TDEC: begin
        if (mem_rdata.delta != 17'd0) begin
          mem_we          = 1'b1;
          mem_waddr       = '0;
          mem_wdata       = mem_rdata;
          mem_wdata.delta = mem_rdata.delta - 17'd1;
        end
        state_d = dlts_pkg::S_TRD;
      end
      dlts_pkg::S_TRD: begin
        if ((n_q != '0) && (k_q < KW'(dlts_pkg::MaxResults))) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_d   = dlts_pkg::S_TCHK;
        end else if (pend_q) begin
          kind_d   = dlts_pkg::K_FIRED;
          res_id_d = pend_id_q;
          state_d  = dlts_pkg::S_EMIT;
        end else begin
          kind_d   = dlts_pkg::K_NONE;
          res_id_d = 8'd0;
          state_d  = dlts_pkg::S_EMIT;
        end
      end
      dlts_pkg::S_TCHK: begin
        if (mem_rdata.delta == 17'd0) begin
          // the previous fire is not last: send it before taking this one
          if (!(pend_q && !out_free)) begin
            if (pend_q) begin
              ov_d    = 1'b1;
              okind_d = dlts_pkg::K_FIRED;
              oid_d   = pend_id_q;
              olast_d = 1'b0;
            end
            pend_d    = 1'b1;
            pend_id_d = mem_rdata.task_id;
            time_d    = mem_rdata.period;
            per_d     = mem_rdata.period;
            id_d      = mem_rdata.task_id;
            k_d       = k_q + KW'(1);
            pos_d     = '0;
            i_d       = '0;
            dd_d      = '0;
            state_d   = dlts_pkg::S_DSRD;
          end
        end else if (pend_q) begin
          kind_d   = dlts_pkg::K_FIRED;
          res_id_d = pend_id_q;
          state_d  = dlts_pkg::S_EMIT;
        end else begin
          kind_d   = dlts_pkg::K_NONE;
          res_id_d = 8'd0;
          state_d  = dlts_pkg::S_EMIT;
        end
      end
      dlts_pkg::S_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = kind_q;
          oid_d   = res_id_q;
          olast_d = 1'b1;
          state_d = dlts_pkg::S_IDLE;
        end
      end
      default: state_d = dlts_pkg::S_IDLE;
    endcase
  end

  assign in_i.ready     = (state_q == dlts_pkg::S_IDLE);
  assign out_o.valid    = ov_q;
  assign out_o.kind     = okind_q;
  assign out_o.fired_id = oid_q;
  assign out_o.last     = olast_q;

  `ASSERT_STD(a_used_bound, n_q <= CntW'(MAX_TASKS))
  `ASSERT_STD(a_fire_cap, k_q <= KW'(dlts_pkg::MaxResults))
  `ASSERT_STD(a_busy_after_cmd, cmd_acc |=> (state_q != dlts_pkg::S_IDLE))
  `ASSERT_STD(a_no_wr_full, (mem_we && (state_q == dlts_pkg::S_PWR)) |-> (n_q < CntW'(MAX_TASKS)))

endmodule

`default_nettype wire

[tb/sv/tb_pkg.sv]
// Scoreboard for the delta-list scheduler testbench: list predictor and result queue.
// Depends on dlts_pkg.
package tb_pkg;
  import dlts_pkg::*;

  typedef struct {
    kind_e      kind;
    logic [7:0] id;
    logic       last;
  } sched_result_t;

  class sched_scoreboard;
    int unsigned   delta_q[$];
    int unsigned   period_q[$];
    logic [7:0]    task_q[$];
    sched_result_t pending_q[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned ms_to_ticks(logic [19:0] ms);
      int unsigned t;
      t = ms / 10;
      return (t > TickMax) ? TickMax : t;
    endfunction

    function void add_result(kind_e k, logic [7:0] id);
      sched_result_t r;
      r.kind = k;
      r.id   = id;
      r.last = 1'b0;
      pending_q.push_back(r);
    endfunction

    function void place(int unsigned tm, int unsigned per, logic [7:0] id, bit after_eq);
      int unsigned pos;
      int unsigned cum;
      int unsigned nxt;
      pos = 0;
      cum = 0;
      if (task_q.size() >= MaxTasks) return;
      while (pos < task_q.size()) begin
        nxt = cum + delta_q[pos];
        if (after_eq ? (nxt > tm) : (nxt >= tm)) break;
        cum = nxt;
        pos++;
      end
      if (pos < task_q.size()) delta_q[pos] -= (tm - cum);
      delta_q.insert(pos, tm - cum);
      period_q.insert(pos, per);
      task_q.insert(pos, id);
    endfunction

    function void remove(int unsigned pos);
      if (pos + 1 < task_q.size()) delta_q[pos + 1] += delta_q[pos];
      delta_q.delete(pos);
      period_q.delete(pos);
      task_q.delete(pos);
    endfunction

    // Note an accepted command and queue the results it must produce.
    function void note_command(op_e op, logic [19:0] dly, logic [19:0] per, logic [7:0] id);
      int          fired;
      logic [7:0]  tid;
      int unsigned tp;
      bit          found;
      fired = 0;
      found = 0;
      case (op)
        OP_TICK: begin
          if (task_q.size() > 0 && delta_q[0] > 0) delta_q[0]--;
          while (task_q.size() > 0 && delta_q[0] == 0 && fired < MaxResults) begin
            tid = task_q[0];
            tp  = period_q[0];
            remove(0);
            add_result(K_FIRED, tid);
            fired++;
            if (tp > 0) place(tp, tp, tid, 1'b1);
          end
          if (fired == 0) add_result(K_NONE, 8'd0);
        end
        OP_INSERT: begin
          if (task_q.size() >= MaxTasks) add_result(K_FULL, id);
          else begin
            place(ms_to_ticks(dly), ms_to_ticks(per), id, 1'b0);
            add_result(K_INSERTED, id);
          end
        end
        OP_DELETE: begin
          for (int i = 0; i < task_q.size(); i++) begin
            if (task_q[i] == id) begin
              remove(i);
              found = 1;
              break;
            end
          end
          add_result(found ? K_DELETED : K_NOTFOUND, id);
        end
        default: return;
      endcase
      pending_q[pending_q.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest expectation.
    task check_result(logic [2:0] k, logic [7:0] id, logic l);
      sched_result_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0d id=%0d", k, id));
        return;
      end
      e = pending_q.pop_front();
      if (k !== e.kind) report($sformatf("kind %0d, want %0d", k, e.kind));
      if (id !== e.id) report($sformatf("fired_id %0d, want %0d", id, e.id));
      if (l !== e.last) report($sformatf("last %0d, want %0d", l, e.last));
    endtask

    function int unsigned used();
      return task_q.size();
    endfunction
  endclass
endpackage

[tb/sv/tb.sv]
// Top-level testbench of delta_list_task_scheduler_core: drives commands, checks results.
// Depends on dlts_pkg, tb_pkg, dlts_in_if, dlts_out_if and the scheduler RTL.
module tb;
  import dlts_pkg::*;
  import tb_pkg::*;

  localparam int CycleLimit = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  dlts_in_if  cmd_if ();
  dlts_out_if res_if ();

  delta_list_task_scheduler_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  sched_scoreboard sb = new();

  // Idle percentages of sender and receiver, changed per phase.
  int unsigned src_idle = 0;
  int unsigned snk_idle = 0;
  int          cycles   = 0;
  int          n_cmds   = 0;
  int          n_res    = 0;

  initial begin
    cmd_if.valid     = 1'b0;
    cmd_if.operation = OP_TICK;
    cmd_if.delay_ms  = '0;
    cmd_if.period_ms = '0;
    cmd_if.task_id   = '0;
    res_if.ready     = 1'b0;
  end

  // Receiver: ready drawn at random at the falling edge, each transaction checked at the rising.
  always @(negedge clk_i) res_if.ready <= ($urandom_range(99) >= snk_idle);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (res_if.valid && res_if.ready && rst_ni) begin
      sb.check_result(res_if.kind, res_if.fired_id, res_if.last);
      n_res <= n_res + 1;
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one command; called and returns at a falling edge. valid stays up after the
  // accepting edge until the next call drives it, so it gets one update per edge.
  task automatic send_cmd(op_e op, logic [19:0] dly, logic [19:0] per, logic [7:0] id);
    while ($urandom_range(99) < src_idle) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.delay_ms  <= dly;
    cmd_if.period_ms <= per;
    cmd_if.task_id   <= id;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(op, dly, per, id);
    n_cmds++;
    @(negedge clk_i);
  endtask

  // Random command mix: mostly short delays so tasks fire, ids from a small pool to hit deletes.
  task automatic send_random();
    int unsigned sel;
    logic [19:0] dly;
    logic [19:0] per;
    sel = $urandom_range(99);
    dly = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(80));
    per = ($urandom_range(3) == 0) ? 20'd0 :
          (($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(60)));
    if (sel < 45) send_cmd(OP_TICK, 20'($urandom), 20'($urandom), 8'($urandom));
    else if (sel < 75) send_cmd(OP_INSERT, dly, per,
                                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)));
    else if (sel < 95) send_cmd(OP_DELETE, 20'($urandom), 20'($urandom),
                                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)));
    else send_cmd(OP_NOP, 20'($urandom), 20'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty tick, missing delete, zero delay, saturation, equal due times.
    src_idle = 13;
    snk_idle = 79;
    send_cmd(OP_TICK, 20'd0, 20'd0, 8'd0);
    send_cmd(OP_DELETE, 20'd0, 20'd0, 8'hFF);
    send_cmd(OP_INSERT, 20'd0, 20'd0, 8'd0);
    send_cmd(OP_INSERT, 20'hFFFFF, 20'hFFFFF, 8'hFF);
    send_cmd(OP_INSERT, 20'd9, 20'd5, 8'd1);
    send_cmd(OP_INSERT, 20'd29, 20'd20, 8'd2);
    send_cmd(OP_INSERT, 20'd20, 20'd0, 8'd3);
    send_cmd(OP_NOP, 20'hFFFFF, 20'hFFFFF, 8'hFF);
    send_cmd(OP_TICK, 20'd0, 20'd0, 8'd0);
    send_cmd(OP_TICK, 20'hFFFFF, 20'hFFFFF, 8'hFF);
    send_cmd(OP_TICK, 20'd0, 20'd0, 8'd0);
    send_cmd(OP_DELETE, 20'd0, 20'd0, 8'hFF);
    // Fill the table with equal periods, then one more for the full case.
    for (int i = 0; sb.used() < MaxTasks; i++)
      send_cmd(OP_INSERT, 20'd10, 20'd10, 8'(8'h10 + i));
    send_cmd(OP_INSERT, 20'd10, 20'd10, 8'hAA);
    send_cmd(OP_TICK, 20'd0, 20'd0, 8'd0);
    send_cmd(OP_TICK, 20'd0, 20'd0, 8'd0);
    for (int i = 0; i < 16; i++) send_cmd(OP_DELETE, 20'd0, 20'd0, 8'(8'h10 + i));

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 13 : (ph == 1) ? 79 : 0;
      snk_idle = (ph == 0) ? 79 : (ph == 1) ? 13 : 0;
      for (int i = 0; i < 18; i++) send_random();
    end
    cmd_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Ran %0d commands (ticks, inserts, deletes, unused code), %0d results checked.",
             n_cmds, n_res);
    $display("Covered full table, saturation, equal due times and three idle mixes.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[delta_list_task_scheduler_core.f]
+incdir+src
src/dlts_pkg.sv
src/dlts_in_if.sv
src/dlts_out_if.sv
src/dlts_mem.sv
src/dlts_conv.sv
src/delta_list_task_scheduler_core.sv
tb/sv/tb_pkg.sv
tb/sv/tb.sv
